// ----- rtl/rectangle_bitmap_rasterizer_assert.svh -----
// assertion macros shared by the rasterizer modules
// expects clock and reset in scope of the module that uses them
`ifndef RECTANGLE_BITMAP_RASTERIZER_ASSERT_SVH
`define RECTANGLE_BITMAP_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define RBR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RBR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rbr_pkg.sv -----
// shared types and constants of the rectangle bitmap rasterizer
// no dependencies
`default_nettype none

package rbr_pkg;

   localparam int unsigned DEF_MAX_RECTS  = 8;
   localparam int unsigned DEF_COORD_BITS = 10;

   localparam int unsigned ADDR_W       = 17;
   localparam int unsigned DIM_W        = 10;
   localparam int unsigned RIDX_W       = 3;
   localparam int unsigned RCNT_W       = 4;
   localparam int unsigned PIX_PER_BYTE = 8;
   localparam int unsigned LAST_PIX     = 7;
   localparam int unsigned BIT_W        = $clog2(PIX_PER_BYTE);
   localparam int unsigned BASE_W       = ADDR_W + BIT_W;
   localparam int unsigned DIV_STEPS    = BASE_W;
   localparam int unsigned STEP_W       = $clog2(DIV_STEPS);

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = DIM_W;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT  = 2'd2;

   localparam logic [DIM_W-1:0]  WIDTH_RESET  = 10'd64;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET = 10'd32;
   localparam logic [RCNT_W-1:0] COUNT_RESET  = 4'd0;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_COMPOSE = 1'b1;

   typedef struct packed {
      logic load_req;
      logic wr_rect;
      logic mul;
      logic div_init;
      logic div_step;
      logic lane_step;
      logic scan_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic fits;
      logic scan_more;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/rbr_ctrl.sv -----
// sequencer of the rasterizer: accept, size check, divide, lane setup, scan, output
// depends on rbr_pkg and rectangle_bitmap_rasterizer_assert.svh
`default_nettype none
`include "rectangle_bitmap_rasterizer_assert.svh"

module rbr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_operation,
   input  wire rbr_pkg::sts_type sts,
   output rbr_pkg::cmd_type      cmd
);
   import rbr_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_LANE  = 3'd4;
   localparam logic [2:0] S_SCAN  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_COMPOSE) begin
                  cmd.load_req = 1'b1;
                  state_in     = S_MUL;
               end else begin
                  cmd.wr_rect = 1'b1;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            step_in = '0;
            if (sts.fits) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_LANE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_LANE: begin
            cmd.lane_step = 1'b1;
            if (step_ff == STEP_W'(LAST_PIX)) begin
               step_in  = '0;
               state_in = S_SCAN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (sts.scan_more) begin
               cmd.scan_step = 1'b1;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `RBR_ASSERT_IMPL(a_out_load_free, cmd.out_load, sts.out_free, "result loaded into busy output")
   `RBR_ASSERT_NEXT(a_compose_starts, accept && req_operation == OP_COMPOSE, state_ff == S_MUL,
      "compose beat did not start the size check")
   `RBR_ASSERT_IMPL(a_div_steps, state_ff == S_DIV, step_ff < STEP_W'(DIV_STEPS),
      "divider step count out of range")

endmodule

`default_nettype wire

// ----- rtl/rbr_dpath.sv -----
// datapath of the rasterizer: config registers, rectangle memory, divider,
// pixel lanes, coverage compare and output register; depends on rbr_pkg
`default_nettype none
`include "rectangle_bitmap_rasterizer_assert.svh"

module rbr_dpath #(
   parameter int unsigned MAX_RECTS  = rbr_pkg::DEF_MAX_RECTS,
   parameter int unsigned COORD_BITS = rbr_pkg::DEF_COORD_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rbr_pkg::cmd_type              cmd,
   output rbr_pkg::sts_type                   sts,
   input  wire logic [rbr_pkg::RIDX_W-1:0]    req_rect_index,
   input  wire logic [rbr_pkg::DIM_W-1:0]     req_rect_left,
   input  wire logic [rbr_pkg::DIM_W-1:0]     req_rect_top,
   input  wire logic [rbr_pkg::DIM_W-1:0]     req_rect_right,
   input  wire logic [rbr_pkg::DIM_W-1:0]     req_rect_bottom,
   input  wire logic [rbr_pkg::ADDR_W-1:0]    req_byte_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rbr_pkg::ADDR_W-1:0]         rsp_out_address,
   output logic [rbr_pkg::PIX_PER_BYTE-1:0]   rsp_pixel_byte,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rbr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rbr_pkg::*;

   localparam int unsigned IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int unsigned LIM_W   = $clog2(MAX_RECTS + 1);
   localparam int unsigned ENTRY_W = 4 * COORD_BITS;
   localparam int unsigned CMP_W   = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

   // config registers
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [RCNT_W-1:0] count_ff;

   // request and size check
   logic [ADDR_W-1:0]  addr_ff;
   logic [BASE_W-1:0]  total_ff;
   logic [BASE_W-1:0]  base;
   logic [BASE_W:0]    base_end;

   // rectangle store
   logic [ENTRY_W-1:0] rect_mem [MAX_RECTS];
   logic [MAX_RECTS-1:0] rect_vld_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_live_ff;
   logic [LIM_W-1:0]   rect_ctr_ff;
   logic [LIM_W-1:0]   lim;
   logic [IDX_W-1:0]   rd_addr;

   // divider
   logic [BASE_W-1:0]  div_quo_ff;
   logic [DIM_W-1:0]   div_rem_ff;
   logic [DIM_W:0]     div_trial;
   logic               div_ge;
   logic [DIM_W:0]     rem_inc;

   // pixel lanes and coverage
   logic [DIM_W-1:0]        x_lane_ff [PIX_PER_BYTE];
   logic [DIM_W-1:0]        y_lane_ff [PIX_PER_BYTE];
   logic [PIX_PER_BYTE-1:0] cover_ff;
   logic [PIX_PER_BYTE-1:0] hit;
   logic [CMP_W-1:0]        e_left, e_top, e_right, e_bottom;
   logic [CMP_W-1:0]        px, py;

   // output register
   logic                    rsp_valid_ff;
   logic [ADDR_W-1:0]       rsp_addr_ff;
   logic [PIX_PER_BYTE-1:0] rsp_byte_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         count_ff  <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            REG_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            REG_COUNT:  count_ff  <= csr_wdata[RCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign base     = {addr_ff, {BIT_W{1'b0}}};
   assign base_end = {1'b0, base} + (BASE_W + 1)'(PIX_PER_BYTE);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         addr_ff <= req_byte_address;
      end
      if (cmd.mul) begin
         total_ff <= BASE_W'(width_ff * height_ff);
      end
   end

   assign sts.fits = (base_end <= {1'b0, total_ff});

   // rectangle memory with per-entry valid bits
   assign wr_en   = cmd.wr_rect && (32'(req_rect_index) < MAX_RECTS);
   assign wr_addr = IDX_W'(req_rect_index);
   assign wr_data = {COORD_BITS'(req_rect_left), COORD_BITS'(req_rect_top),
                     COORD_BITS'(req_rect_right), COORD_BITS'(req_rect_bottom)};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rect_mem[wr_addr] <= wr_data;
      end
   end

   assign lim       = (32'(count_ff) > MAX_RECTS) ? LIM_W'(MAX_RECTS) : LIM_W'(count_ff);
   assign rd_addr   = rect_ctr_ff[IDX_W-1:0];
   assign sts.scan_more = (rect_ctr_ff < lim);

   always_ff @(posedge clock) begin
      rd_data_ff <= rect_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_vld_ff <= '0;
         rd_live_ff  <= 1'b0;
         rect_ctr_ff <= '0;
      end else begin
         if (wr_en) begin
            rect_vld_ff[wr_addr] <= 1'b1;
         end
         rd_live_ff <= cmd.scan_step && rect_vld_ff[rd_addr];
         if (cmd.load_req) begin
            rect_ctr_ff <= '0;
         end else if (cmd.scan_step) begin
            rect_ctr_ff <= rect_ctr_ff + 1'b1;
         end
      end
   end

   // restoring divider, one quotient bit per step; then walk x/y per pixel
   assign div_trial = {div_rem_ff, div_quo_ff[BASE_W-1]};
   assign div_ge    = (div_trial >= {1'b0, width_ff});
   assign rem_inc   = {1'b0, div_rem_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_quo_ff <= base;
         div_rem_ff <= '0;
      end else if (cmd.div_step) begin
         div_quo_ff <= {div_quo_ff[BASE_W-2:0], div_ge};
         div_rem_ff <= div_ge ? DIM_W'(div_trial - {1'b0, width_ff}) : div_trial[DIM_W-1:0];
      end else if (cmd.lane_step) begin
         if (rem_inc == {1'b0, width_ff}) begin
            div_rem_ff <= '0;
            div_quo_ff <= div_quo_ff + 1'b1;
         end else begin
            div_rem_ff <= rem_inc[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lane_step) begin
         for (int k = 0; k < PIX_PER_BYTE - 1; k++) begin
            x_lane_ff[k] <= x_lane_ff[k+1];
            y_lane_ff[k] <= y_lane_ff[k+1];
         end
         x_lane_ff[PIX_PER_BYTE-1] <= div_rem_ff;
         y_lane_ff[PIX_PER_BYTE-1] <= div_quo_ff[DIM_W-1:0];
      end
   end

   assign e_left   = CMP_W'(rd_data_ff[4*COORD_BITS-1:3*COORD_BITS]);
   assign e_top    = CMP_W'(rd_data_ff[3*COORD_BITS-1:2*COORD_BITS]);
   assign e_right  = CMP_W'(rd_data_ff[2*COORD_BITS-1:COORD_BITS]);
   assign e_bottom = CMP_W'(rd_data_ff[COORD_BITS-1:0]);

   always_comb begin
      px  = '0;
      py  = '0;
      hit = '0;
      for (int k = 0; k < PIX_PER_BYTE; k++) begin
         px     = CMP_W'(x_lane_ff[k]);
         py     = CMP_W'(y_lane_ff[k]);
         hit[k] = (px >= e_left) && (px < e_right) && (py >= e_top) && (py < e_bottom);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cover_ff <= '0;
      end else if (rd_live_ff) begin
         cover_ff <= cover_ff | hit;
      end
   end

   // output register
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_addr_ff <= addr_ff;
         rsp_byte_ff <= cover_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_address = rsp_addr_ff;
   assign rsp_pixel_byte  = rsp_byte_ff;

   `RBR_ASSERT_IMPL(a_rem_below_width, cmd.lane_step, div_rem_ff < width_ff,
      "pixel column not below frame width")
   `RBR_ASSERT_IMPL(a_row_below_height, cmd.lane_step, div_quo_ff < BASE_W'(height_ff),
      "pixel row not below frame height")
   `RBR_ASSERT_NEXT(a_rsp_hold, rsp_valid_ff && rsp_stall,
      rsp_valid_ff && $stable(rsp_addr_ff) && $stable(rsp_byte_ff),
      "stalled result beat changed")

endmodule

`default_nettype wire

// ----- rtl/rectangle_bitmap_rasterizer.sv -----
// Rectangle bitmap rasterizer, 1 bit per pixel. A write beat (operation 0) stores a
// rectangle at rect_index; writes to an index at or above MAX_RECTS are dropped. A
// compose beat (operation 1) builds frame byte byte_address, bit k being pixel
// 8*address+k, set when one of the first rect_count entries covers it (left/top
// inclusive, right/bottom exclusive). Bytes not wholly inside width*height give no
// result. For an emitted byte, a 20-step restoring divider finds the first pixel's
// row and column, 8 steps load the pixel lanes, then one rectangle a cycle, of
// min(rect_count, MAX_RECTS) in all, is read from the table and compared against all
// eight pixels. The next beat is taken while a result waits on rsp_stall.
// Depends on rbr_pkg, rbr_ctrl and rbr_dpath.
`default_nettype none

module rectangle_bitmap_rasterizer #(
   parameter int unsigned MAX_RECTS  = rbr_pkg::DEF_MAX_RECTS,
   parameter int unsigned COORD_BITS = rbr_pkg::DEF_COORD_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_operation,
   input  wire logic [rbr_pkg::RIDX_W-1:0]     req_rect_index,
   input  wire logic [rbr_pkg::DIM_W-1:0]      req_rect_left,
   input  wire logic [rbr_pkg::DIM_W-1:0]      req_rect_top,
   input  wire logic [rbr_pkg::DIM_W-1:0]      req_rect_right,
   input  wire logic [rbr_pkg::DIM_W-1:0]      req_rect_bottom,
   input  wire logic [rbr_pkg::ADDR_W-1:0]     req_byte_address,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [rbr_pkg::ADDR_W-1:0]          rsp_out_address,
   output logic [rbr_pkg::PIX_PER_BYTE-1:0]    rsp_pixel_byte,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [rbr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rbr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rbr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rbr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   rbr_dpath #(
      .MAX_RECTS  (MAX_RECTS),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_rect_index   (req_rect_index),
      .req_rect_left    (req_rect_left),
      .req_rect_top     (req_rect_top),
      .req_rect_right   (req_rect_right),
      .req_rect_bottom  (req_rect_bottom),
      .req_byte_address (req_byte_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_address  (rsp_out_address),
      .rsp_pixel_byte   (rsp_pixel_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

`default_nettype wire
